// ----- rtl/bitmap_text_plotter_macros.svh -----
// ---------------------------------------------------------------------------
// Bitmap text plotter assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BITMAP_TEXT_PLOTTER_MACROS_SVH
`define BITMAP_TEXT_PLOTTER_MACROS_SVH

// same-cycle implication
`define BTP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/btp_pkg.sv -----
// ---------------------------------------------------------------------------
// Bitmap text plotter package
// Geometry constants, command types, font table and clipping helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package btp_pkg;

	localparam int FRAME_WIDTH  = 400;
	localparam int FRAME_HEIGHT = 300;
	localparam int ROW_BYTES    = (FRAME_WIDTH + 7) / 8;
	localparam int FRAME_BYTES  = ROW_BYTES * FRAME_HEIGHT;
	localparam int AW           = $clog2(FRAME_BYTES);
	localparam int XW           = $clog2(FRAME_WIDTH);
	localparam int YW           = $clog2(FRAME_HEIGHT);
	localparam int BCOL_W       = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	localparam int PW           = BCOL_W + 3;
	localparam int GLYPH_COUNT  = 40;
	localparam int GLYPH_COLS   = 5;
	localparam int GLYPH_ROWS   = 7;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_FILL  = 2'd1;
	localparam logic [1:0] KIND_CHAR  = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_CLEAR,
		OP_FILL,
		OP_GLYPH,
		OP_READ
	} op_t;

	typedef struct packed {
		logic          empty;
		logic [XW-1:0] x0;
		logic [XW-1:0] x1m1;
		logic [YW-1:0] y0;
		logic [YW-1:0] y1m1;
	} rect_t;

	typedef struct packed {
		op_t                op;
		rect_t              rect;
		logic signed [10:0] gx;
		logic signed [10:0] gy;
		logic [3:0]         scale;
		logic [5:0]         slot;
		logic [AW-1:0]      addr;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	typedef struct packed {
		logic pop;
		logic init_done;
	} back_ctl_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] slot;
	} glyph_t;

	// columns of each glyph, bit r is row r; A..Z, 0..9, '-', '.', ':', '/'
	localparam logic [6:0] FONT [GLYPH_COUNT][GLYPH_COLS] = '{
		'{7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E}, '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h36},
		'{7'h3E, 7'h41, 7'h41, 7'h41, 7'h22}, '{7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C},
		'{7'h7F, 7'h49, 7'h49, 7'h49, 7'h41}, '{7'h7F, 7'h09, 7'h09, 7'h09, 7'h01},
		'{7'h3E, 7'h41, 7'h49, 7'h49, 7'h3A}, '{7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F},
		'{7'h00, 7'h41, 7'h7F, 7'h41, 7'h00}, '{7'h20, 7'h40, 7'h41, 7'h3F, 7'h01},
		'{7'h7F, 7'h08, 7'h14, 7'h22, 7'h41}, '{7'h7F, 7'h40, 7'h40, 7'h40, 7'h40},
		'{7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F}, '{7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F},
		'{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E}, '{7'h7F, 7'h09, 7'h09, 7'h09, 7'h06},
		'{7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E}, '{7'h7F, 7'h09, 7'h19, 7'h29, 7'h46},
		'{7'h26, 7'h49, 7'h49, 7'h49, 7'h32}, '{7'h01, 7'h01, 7'h7F, 7'h01, 7'h01},
		'{7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F}, '{7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F},
		'{7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F}, '{7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
		'{7'h07, 7'h08, 7'h70, 7'h08, 7'h07}, '{7'h61, 7'h51, 7'h49, 7'h45, 7'h43},
		'{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E}, '{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00},
		'{7'h42, 7'h61, 7'h51, 7'h49, 7'h46}, '{7'h21, 7'h41, 7'h45, 7'h4B, 7'h31},
		'{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10}, '{7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
		'{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30}, '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
		'{7'h36, 7'h49, 7'h49, 7'h49, 7'h36}, '{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E},
		'{7'h08, 7'h08, 7'h08, 7'h08, 7'h08}, '{7'h00, 7'h60, 7'h60, 7'h00, 7'h00},
		'{7'h00, 7'h00, 7'h36, 7'h36, 7'h00}, '{7'h20, 7'h10, 7'h08, 7'h04, 7'h02}
	};

	function automatic glyph_t glyph_slot(input logic [7:0] code);
		logic [7:0] c;
		glyph_t     g;
		g = '0;
		c = code;
		if (c inside {[8'h61:8'h7A]}) c = c - 8'h20;
		if (c inside {[8'h41:8'h5A]}) begin
			g.valid = 1'b1;
			g.slot  = 6'(c - 8'h41);
		end else if (c inside {[8'h30:8'h39]}) begin
			g.valid = 1'b1;
			g.slot  = 6'(c - 8'h30) + 6'd26;
		end else if (c == 8'h2D) begin
			g.valid = 1'b1;
			g.slot  = 6'd36;
		end else if (c == 8'h2E) begin
			g.valid = 1'b1;
			g.slot  = 6'd37;
		end else if (c == 8'h3A) begin
			g.valid = 1'b1;
			g.slot  = 6'd38;
		end else if (c == 8'h2F) begin
			g.valid = 1'b1;
			g.slot  = 6'd39;
		end
		return g;
	endfunction

	function automatic logic [6:0] font_col(input logic [5:0] slot, input logic [2:0] col);
		logic [6:0] bits;
		bits = '0;
		if (slot < 6'(GLYPH_COUNT) && col < 3'(GLYPH_COLS)) bits = FONT[slot][col];
		return bits;
	endfunction

	function automatic rect_t clip_rect(input logic signed [12:0] x, input logic signed [12:0] y,
		input logic [9:0] w, input logic [9:0] h);
		logic signed [13:0] xs, ys, xe, ye, x0, y0, x1, y1;
		rect_t r;
		xs = 14'(x);
		ys = 14'(y);
		xe = xs + $signed({4'b0, w});
		ye = ys + $signed({4'b0, h});
		x0 = (xs < 0) ? 14'sd0 : xs;
		y0 = (ys < 0) ? 14'sd0 : ys;
		x1 = (xe > 14'(FRAME_WIDTH)) ? 14'(FRAME_WIDTH) : xe;
		y1 = (ye > 14'(FRAME_HEIGHT)) ? 14'(FRAME_HEIGHT) : ye;
		r.empty = (x1 <= x0) || (y1 <= y0);
		r.x0    = XW'(x0);
		r.x1m1  = XW'(x1 - 14'sd1);
		r.y0    = YW'(y0);
		r.y1m1  = YW'(y1 - 14'sd1);
		return r;
	endfunction

endpackage

// ----- rtl/bitmap_text_plotter.sv -----
// ---------------------------------------------------------------------------
// Bitmap text plotter
// 1-bit frame store with clear, fill, glyph draw and byte read commands.
// ---------------------------------------------------------------------------
// After reset the frame RAM is swept to white, during which cmd_stall
// stays high. Every command returns one item. Commands work on the frame
// RAM, which has one write and one read port: a clear sweeps every byte,
// a fill reads and rewrites each touched byte, a glyph scans its 35 font
// cells and fills the scaled square of each lit cell inside the frame, a
// read fetches one byte and a no-op touches no byte.
// The final step of each command waits while an earlier item is still held
// by res_stall. A two-entry queue lets the next commands be taken while one
// is running.
`timescale 1ns / 1ps

module bitmap_text_plotter import btp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         kind,
	input  logic signed [10:0] origin_x,
	input  logic signed [10:0] origin_y,
	input  logic [9:0]         rect_width,
	input  logic [9:0]         rect_height,
	input  logic [7:0]         char_code,
	input  logic [3:0]         scale,
	input  logic [13:0]        byte_addr,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [7:0]         read_data
);

	head_t     head;
	back_ctl_t bctl;

	btp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.kind        (kind),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.char_code   (char_code),
		.scale       (scale),
		.byte_addr   (byte_addr),
		.head        (head),
		.bctl        (bctl)
	);

	btp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.bctl      (bctl),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.read_data (read_data)
	);

endmodule

// ----- rtl/btp_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module btp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/btp_front.sv -----
// ---------------------------------------------------------------------------
// Bitmap text plotter front end
// Accepts commands, clips rectangles, resolves glyphs and queues the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module btp_front import btp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         kind,
	input  logic signed [10:0] origin_x,
	input  logic signed [10:0] origin_y,
	input  logic [9:0]         rect_width,
	input  logic [9:0]         rect_height,
	input  logic [7:0]         char_code,
	input  logic [3:0]         scale,
	input  logic [13:0]        byte_addr,
	output head_t              head,
	input  back_ctl_t          bctl
);
`include "bitmap_text_plotter_macros.svh"

	cmd_t       ent;
	cmd_t       ent_q [2];
	logic [1:0] count_q;
	logic       wp_q, rp_q;
	logic       push;
	glyph_t     gs;
	rect_t      rr;

	always_comb begin
		gs = glyph_slot(char_code);
		rr = clip_rect(13'(origin_x), 13'(origin_y), rect_width, rect_height);
		ent       = '0;
		ent.rect  = rr;
		ent.gx    = origin_x;
		ent.gy    = origin_y;
		ent.scale = scale;
		ent.slot  = gs.slot;
		ent.addr  = AW'(byte_addr);
		case (kind)
			KIND_CLEAR: ent.op = OP_CLEAR;
			KIND_FILL:  ent.op = rr.empty ? OP_NOP : OP_FILL;
			KIND_CHAR:  ent.op = (gs.valid && scale != 4'd0) ? OP_GLYPH : OP_NOP;
			KIND_READ:  ent.op = (byte_addr < 14'(FRAME_BYTES)) ? OP_READ : OP_NOP;
			default:    ent.op = OP_NOP;
		endcase
	end

	assign cmd_stall  = !bctl.init_done || count_q == 2'd2;
	assign push       = cmd_valid && !cmd_stall;
	assign head.valid = count_q != 2'd0;
	assign head.cmd   = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (bctl.pop) rp_q <= !rp_q;
			count_q <= count_q + 2'(push) - 2'(bctl.pop);
		end
	end

	`BTP_ASSERT_NOW(a_queue_bound, 1'b1, count_q == 2'd0 || count_q == 2'd1 || count_q == 2'd2, "queue overrun")
	`BTP_ASSERT_NOW(a_pop_nonempty, bctl.pop, count_q != 2'd0, "pop from empty queue")
	`BTP_ASSERT_NOW(a_full_stall, count_q == 2'd2, cmd_stall, "full queue not stalling")

endmodule

// ----- rtl/btp_back.sv -----
// ---------------------------------------------------------------------------
// Bitmap text plotter back end
// Runs queued commands against the frame RAM and holds the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module btp_back import btp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  head_t       head,
	output back_ctl_t   bctl,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  read_data
);
`include "bitmap_text_plotter_macros.svh"

	typedef enum logic [3:0] {
		B_CLR, B_IDLE, B_DONE, F_INIT, F_RD, F_WR, G_SCAN, G_NEXT, R_RD, R_WAIT
	} state_t;

	state_t              state_q;
	logic                init_done_q;
	logic                res_valid_q;
	logic [7:0]          read_data_q, res_q;
	logic [AW-1:0]       clr_q, addr_q, rowbase_q, fill_addr;
	logic [XW-1:0]       fx0_q, fx1m1_q;
	logic [YW-1:0]       fy_q, fy1m1_q;
	logic [BCOL_W-1:0]   b_q, bfirst, blast;
	logic                glyph_q;
	logic signed [12:0]  gx_q, gy_q, gyo_q;
	logic [3:0]          scale_q;
	logic [5:0]          slot_q;
	logic [2:0]          col_q, row_q;
	logic [6:0]          gbits;
	rect_t               grect;
	logic [7:0]          mask;
	logic [PW-1:0]       pix;
	logic                we;
	logic [AW-1:0]       waddr, raddr;
	logic [7:0]          wdata, rdata;

	assign bfirst    = BCOL_W'(fx0_q >> 3);
	assign blast     = BCOL_W'(fx1m1_q >> 3);
	assign fill_addr = AW'(rowbase_q + AW'(b_q));
	assign gbits     = font_col(slot_q, col_q);
	assign grect     = clip_rect(gx_q, gy_q, {6'b0, scale_q}, {6'b0, scale_q});

	always_comb begin
		pix  = '0;
		mask = '0;
		for (int k = 0; k < 8; k++) begin
			pix = {b_q, 3'(k)};
			mask[7-k] = (pix >= PW'(fx0_q)) && (pix <= PW'(fx1m1_q));
		end
	end

	assign we    = state_q == B_CLR || state_q == F_WR;
	assign waddr = (state_q == B_CLR) ? clr_q : fill_addr;
	assign wdata = (state_q == B_CLR) ? 8'hFF : (rdata & ~mask);
	assign raddr = (state_q == R_RD) ? addr_q : fill_addr;

	btp_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign bctl.pop       = state_q == B_IDLE && head.valid;
	assign bctl.init_done = init_done_q;
	assign res_valid      = res_valid_q;
	assign read_data      = read_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLR;
			init_done_q <= 1'b0;
			res_valid_q <= 1'b0;
			clr_q       <= '0;
		end else begin
			if (res_valid_q && !res_stall && state_q != B_DONE) res_valid_q <= 1'b0;
			case (state_q)
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(FRAME_BYTES - 1)) begin
						init_done_q <= 1'b1;
						state_q     <= init_done_q ? B_DONE : B_IDLE;
					end
				end
				B_IDLE: begin
					if (head.valid) begin
						res_q   <= '0;
						fx0_q   <= head.cmd.rect.x0;
						fx1m1_q <= head.cmd.rect.x1m1;
						fy_q    <= head.cmd.rect.y0;
						fy1m1_q <= head.cmd.rect.y1m1;
						glyph_q <= 1'b0;
						addr_q  <= head.cmd.addr;
						gx_q    <= 13'(head.cmd.gx);
						gy_q    <= 13'(head.cmd.gy);
						gyo_q   <= 13'(head.cmd.gy);
						scale_q <= head.cmd.scale;
						slot_q  <= head.cmd.slot;
						col_q   <= '0;
						row_q   <= '0;
						clr_q   <= '0;
						case (head.cmd.op)
							OP_CLEAR: state_q <= B_CLR;
							OP_FILL:  state_q <= F_INIT;
							OP_GLYPH: state_q <= G_SCAN;
							OP_READ:  state_q <= R_RD;
							default:  state_q <= B_DONE;
						endcase
					end
				end
				F_INIT: begin
					rowbase_q <= AW'(fy_q * ROW_BYTES);
					b_q       <= bfirst;
					state_q   <= F_RD;
				end
				F_RD: state_q <= F_WR;
				F_WR: begin
					if (b_q == blast) begin
						b_q <= bfirst;
						if (fy_q == fy1m1_q) begin
							state_q <= glyph_q ? G_NEXT : B_DONE;
						end else begin
							state_q   <= F_RD;
							fy_q      <= fy_q + 1'b1;
							rowbase_q <= rowbase_q + AW'(ROW_BYTES);
						end
					end else begin
						state_q <= F_RD;
						b_q     <= b_q + 1'b1;
					end
				end
				G_SCAN: begin
					if (gbits[row_q] && !grect.empty) begin
						fx0_q   <= grect.x0;
						fx1m1_q <= grect.x1m1;
						fy_q    <= grect.y0;
						fy1m1_q <= grect.y1m1;
						glyph_q <= 1'b1;
						state_q <= F_INIT;
					end else begin
						state_q <= G_NEXT;
					end
				end
				G_NEXT: begin
					if (row_q == 3'(GLYPH_ROWS - 1)) begin
						row_q <= '0;
						gy_q  <= gyo_q;
						if (col_q == 3'(GLYPH_COLS - 1)) begin
							state_q <= B_DONE;
						end else begin
							state_q <= G_SCAN;
							col_q   <= col_q + 1'b1;
							gx_q    <= gx_q + $signed({9'b0, scale_q});
						end
					end else begin
						state_q <= G_SCAN;
						row_q   <= row_q + 1'b1;
						gy_q    <= gy_q + $signed({9'b0, scale_q});
					end
				end
				R_RD: state_q <= R_WAIT;
				R_WAIT: begin
					res_q   <= rdata;
					state_q <= B_DONE;
				end
				B_DONE: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						read_data_q <= res_q;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`BTP_ASSERT_NOW(a_wr_range, we, waddr < AW'(FRAME_BYTES), "frame write out of range")
	`BTP_ASSERT_NOW(a_mask_live, state_q == F_WR, mask != 8'h00, "byte outside fill span")
	`BTP_ASSERT_NEXT(a_init_hold, init_done_q, init_done_q, "init flag dropped")

endmodule
